[src/horizontal_diffusion_stencil_top_macros.svh]
// Assertion macros for the horizontal diffusion stencil.
// Included by the files that assert; they expand to nothing under synthesis.
`ifndef HORIZONTAL_DIFFUSION_STENCIL_TOP_MACROS_SVH
`define HORIZONTAL_DIFFUSION_STENCIL_TOP_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define HDS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every edge, reset included
`define HDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HDS_ASSERT(lbl, clk, rstn, prop, msg)
`define HDS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[src/hdiff_pkg.sv]
// Shared types, widths and arithmetic helpers of the horizontal diffusion stencil.
// No dependencies; imported by every module of the block.
package hdiff_pkg;

    localparam int DEF_WINDOW_COLUMNS = 64;
    localparam int DEF_WINDOW_ROWS    = 64;

    localparam int SAMPLE_W = 32;
    localparam int COEF_W   = 8;
    localparam int IDX_W    = 6;

    localparam logic [COEF_W-1:0] COEF_RESET = 8'd7;

    // Laplacian weight of 4 is a shift by 2
    localparam int LAPLACE_SHIFT = 2;

    // intermediate widths, exact for any 32-bit input
    localparam int LAP_W  = 35;
    localparam int GRAD_W = 33;
    localparam int FLUX_W = 36;
    localparam int NET_W  = 38;
    localparam int PROD_W = 46;
    localparam int VAL_W  = 47;

    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - SAMPLE_W - 2 * IDX_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [LAP_W-1:0]    lap_t;
    typedef logic signed [GRAD_W-1:0]   grad_t;
    typedef logic signed [FLUX_W-1:0]   flux_t;
    typedef logic signed [NET_W-1:0]    net_t;

    localparam sample_t SAT_MAX = 32'sh7fff_ffff;
    localparam sample_t SAT_MIN = 32'sh8000_0000;

    // Sideband of one stencil point moving down the pipe
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] column_index;
        logic [IDX_W-1:0] row_index;
        logic             window_done;
    } point_t;

    // Thirteen stencil taps; c = center column, e = next column,
    // w = previous column, ww = two back, ee = two ahead; suffix is row offset
    typedef struct packed {
        sample_t c_0;
        sample_t c_m1;
        sample_t c_p1;
        sample_t c_m2;
        sample_t c_p2;
        sample_t w_0;
        sample_t w_m1;
        sample_t w_p1;
        sample_t e_0;
        sample_t e_m1;
        sample_t e_p1;
        sample_t ww_0;
        sample_t ee_0;
    } taps_t;

    // 4*mid minus the four neighbors
    function automatic lap_t lap_f(sample_t mid, sample_t a, sample_t b,
                                   sample_t c, sample_t d);
        return (LAP_W'(mid) <<< LAPLACE_SHIFT) - LAP_W'(a) - LAP_W'(b)
               - LAP_W'(c) - LAP_W'(d);
    endfunction

    function automatic grad_t grad_f(sample_t hi, sample_t lo);
        return GRAD_W'(hi) - GRAD_W'(lo);
    endfunction

    // Flux is dropped when it points the same way as the gradient
    function automatic flux_t limit_f(flux_t flux, grad_t grad);
        logic same_sign;
        same_sign = ((flux > 0) && (grad > 0)) || ((flux < 0) && (grad < 0));
        return same_sign ? '0 : flux;
    endfunction

endpackage

[src/hdiff_store.sv]
// Position counters, four-column sample store and stencil tap assembly.
// Depends on hdiff_pkg and the assertion macro header.
`include "horizontal_diffusion_stencil_top_macros.svh"

module hdiff_store
    import hdiff_pkg::*;
#(
    parameter int WINDOW_COLUMNS = DEF_WINDOW_COLUMNS,
    parameter int WINDOW_ROWS    = DEF_WINDOW_ROWS
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    accept,
    input  logic    advance,
    input  sample_t sample,
    input  logic    window_start,
    output taps_t   taps,
    output point_t  point
);

    localparam int COL_W     = $clog2(WINDOW_COLUMNS);
    localparam int ROW_W     = $clog2(WINDOW_ROWS);
    localparam int NUM_BANKS = 4;
    localparam int BANK_W    = 2;

    // bank roles relative to the incoming column p
    localparam logic [BANK_W-1:0] ROLE_OLD  = 2'd0;  // column p-4, same bank as p
    localparam logic [BANK_W-1:0] ROLE_EAST = 2'd1;  // column p-1
    localparam logic [BANK_W-1:0] ROLE_CTR  = 2'd2;  // column p-2, center
    localparam logic [BANK_W-1:0] ROLE_WEST = 2'd3;  // column p-3

    logic [COL_W-1:0]  col_pos_reg, col_pos_next, col_cur;
    logic [ROW_W-1:0]  row_pos_reg, row_pos_next, row_cur;
    logic [ROW_W:0]    row_p1_ext, row_p2_ext;
    logic [ROW_W-1:0]  row_p1, row_p2, row_m1;
    logic [BANK_W-1:0] slot, slot_reg;
    logic [BANK_W-1:0] bank_ctr, bank_east, bank_west;
    logic [ROW_W-1:0]  addr_a [NUM_BANKS];
    logic              emit;
    point_t            point_next, point_reg;
    sample_t           sample_reg;

    sample_t column_store_reg [NUM_BANKS][WINDOW_ROWS];
    sample_t rd_a_reg   [NUM_BANKS];
    sample_t rd_b_reg   [NUM_BANKS];
    sample_t hist_a1_reg[NUM_BANKS];
    sample_t hist_a2_reg[NUM_BANKS];
    sample_t hist_b1_reg[NUM_BANKS];

    // position of this item and of the next one
    always_comb begin
        col_cur      = window_start ? '0 : col_pos_reg;
        row_cur      = window_start ? '0 : row_pos_reg;
        col_pos_next = col_cur;
        row_pos_next = row_cur + 1'b1;
        if (row_cur == ROW_W'(WINDOW_ROWS - 1)) begin
            row_pos_next = '0;
            col_pos_next = (col_cur == COL_W'(WINDOW_COLUMNS - 1)) ? '0 : col_cur + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end else if (accept) begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

    // interior test and sideband of the point centered two columns back
    always_comb begin
        emit = (col_cur >= COL_W'(4)) && (row_cur >= ROW_W'(2))
               && (row_cur <= ROW_W'(WINDOW_ROWS - 3));
        point_next.valid        = accept && emit;
        point_next.column_index = IDX_W'(col_cur - COL_W'(2));
        point_next.row_index    = IDX_W'(row_cur);
        point_next.window_done  = (col_cur == COL_W'(WINDOW_COLUMNS - 1))
                                  && (row_cur == ROW_W'(WINDOW_ROWS - 3));
    end

    // read rows, clamped into the bank; clamped reads only feed border points
    always_comb begin
        row_p1_ext = {1'b0, row_cur} + (ROW_W+1)'(1);
        row_p2_ext = {1'b0, row_cur} + (ROW_W+1)'(2);
        row_p1 = (row_p1_ext >= (ROW_W+1)'(WINDOW_ROWS)) ? '0 : row_p1_ext[ROW_W-1:0];
        row_p2 = (row_p2_ext >= (ROW_W+1)'(WINDOW_ROWS)) ? '0 : row_p2_ext[ROW_W-1:0];
        row_m1 = (row_cur == '0) ? '0 : row_cur - 1'b1;
        slot   = col_cur[BANK_W-1:0];
        for (int b = 0; b < NUM_BANKS; b++) begin
            case (BANK_W'(slot - BANK_W'(b)))
                ROLE_OLD: addr_a[b] = row_cur;
                ROLE_CTR: addr_a[b] = row_p2;
                default:  addr_a[b] = row_p1;
            endcase
        end
    end

    // banks: one write, two registered reads; history shifts per item
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                rd_a_reg[b]    <= column_store_reg[b][addr_a[b]];
                rd_b_reg[b]    <= column_store_reg[b][row_m1];
                hist_a1_reg[b] <= rd_a_reg[b];
                hist_a2_reg[b] <= hist_a1_reg[b];
                hist_b1_reg[b] <= rd_b_reg[b];
            end
            column_store_reg[slot][row_cur] <= sample;
            sample_reg <= sample;
            slot_reg   <= slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_reg.valid <= 1'b0;
        end else if (advance) begin
            point_reg <= point_next;
        end
    end

    // route bank data to taps by column role
    always_comb begin
        bank_ctr  = slot_reg - ROLE_CTR;
        bank_east = slot_reg - ROLE_EAST;
        bank_west = slot_reg - ROLE_WEST;
        taps.c_p2 = rd_a_reg[bank_ctr];
        taps.c_p1 = hist_a1_reg[bank_ctr];
        taps.c_0  = hist_a2_reg[bank_ctr];
        taps.c_m1 = rd_b_reg[bank_ctr];
        taps.c_m2 = hist_b1_reg[bank_ctr];
        taps.e_p1 = rd_a_reg[bank_east];
        taps.e_0  = hist_a1_reg[bank_east];
        taps.e_m1 = hist_a2_reg[bank_east];
        taps.w_p1 = rd_a_reg[bank_west];
        taps.w_0  = hist_a1_reg[bank_west];
        taps.w_m1 = hist_a2_reg[bank_west];
        taps.ww_0 = rd_a_reg[slot_reg];
        taps.ee_0 = sample_reg;
    end

    assign point = point_reg;

    `HDS_ASSERT(a_row_range, aclk, aresetn, row_pos_reg <= ROW_W'(WINDOW_ROWS - 1), "row position past window")
    `HDS_ASSERT(a_col_range, aclk, aresetn, col_pos_reg <= COL_W'(WINDOW_COLUMNS - 1), "column position past window")
    `HDS_ASSERT(a_start_pos, aclk, aresetn, accept && window_start |=> row_pos_reg == ROW_W'(1) && col_pos_reg == '0, "window start did not restart position")

endmodule

[src/hdiff_flux.sv]
// Laplacian, gradient and limited-flux stages of the stencil datapath.
// Depends on hdiff_pkg.
module hdiff_flux
    import hdiff_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  taps_t   taps,
    input  point_t  point_in,
    output net_t    net,
    output sample_t center,
    output point_t  point_out
);

    lap_t    l_ij_reg, l_imj_reg, l_ipj_reg, l_ijm_reg, l_ijp_reg;
    grad_t   gx_reg, gxm_reg, gy_reg, gym_reg;
    sample_t center2_reg, center3_reg;
    point_t  point2_reg, point3_reg;
    flux_t   fx, fxm, fy, fym;
    net_t    net_next, net_reg;

    // stage 2: five Laplacians and four gradients
    always_ff @(posedge aclk) begin
        if (advance) begin
            l_ij_reg    <= lap_f(taps.c_0, taps.c_m1, taps.c_p1, taps.w_0, taps.e_0);
            l_imj_reg   <= lap_f(taps.c_m1, taps.c_m2, taps.c_0, taps.w_m1, taps.e_m1);
            l_ipj_reg   <= lap_f(taps.c_p1, taps.c_0, taps.c_p2, taps.w_p1, taps.e_p1);
            l_ijm_reg   <= lap_f(taps.w_0, taps.w_m1, taps.w_p1, taps.ww_0, taps.c_0);
            l_ijp_reg   <= lap_f(taps.e_0, taps.e_m1, taps.e_p1, taps.c_0, taps.ee_0);
            gx_reg      <= grad_f(taps.c_p1, taps.c_0);
            gxm_reg     <= grad_f(taps.c_0, taps.c_m1);
            gy_reg      <= grad_f(taps.e_0, taps.c_0);
            gym_reg     <= grad_f(taps.c_0, taps.w_0);
            center2_reg <= taps.c_0;
        end
    end

    // stage 3: limited fluxes and their net
    always_comb begin
        fx  = limit_f(FLUX_W'(l_ipj_reg) - FLUX_W'(l_ij_reg), gx_reg);
        fxm = limit_f(FLUX_W'(l_ij_reg) - FLUX_W'(l_imj_reg), gxm_reg);
        fy  = limit_f(FLUX_W'(l_ijp_reg) - FLUX_W'(l_ij_reg), gy_reg);
        fym = limit_f(FLUX_W'(l_ij_reg) - FLUX_W'(l_ijm_reg), gym_reg);
        net_next = (NET_W'(fx) - NET_W'(fxm)) + (NET_W'(fy) - NET_W'(fym));
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            net_reg     <= net_next;
            center3_reg <= center2_reg;
        end
    end

    // sideband follows the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point2_reg.valid <= 1'b0;
            point3_reg.valid <= 1'b0;
        end else if (advance) begin
            point2_reg <= point_in;
            point3_reg <= point2_reg;
        end
    end

    assign net       = net_reg;
    assign center    = center3_reg;
    assign point_out = point3_reg;

endmodule

[src/hdiff_out.sv]
// Coefficient scaling, saturation and the result register.
// Depends on hdiff_pkg.
module hdiff_scale
    import hdiff_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [COEF_W-1:0] coef,
    input  net_t              net,
    input  sample_t           center,
    input  point_t            point_in,
    output sample_t           result,
    output point_t            point_out
);

    logic signed [PROD_W-1:0] prod;
    logic signed [VAL_W-1:0]  val;
    sample_t                  result_next, result_reg;
    point_t                   point_reg;

    // center minus coefficient times net flux, clipped to 32 bits
    always_comb begin
        prod = PROD_W'(net) * PROD_W'($signed({1'b0, coef}));
        val  = VAL_W'(center) - VAL_W'(prod);
        if (val[VAL_W-1:SAMPLE_W-1] != {(VAL_W-SAMPLE_W+1){val[VAL_W-1]}}) begin
            result_next = val[VAL_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            result_next = val[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_reg.valid <= 1'b0;
        end else if (advance) begin
            point_reg <= point_in;
        end
    end

    assign result    = result_reg;
    assign point_out = point_reg;

endmodule

[src/horizontal_diffusion_stencil_top.sv]
// A result item becomes valid once the input item completing it has passed the store
// read, Laplacian, flux and result registers.
// Throughput: one input item per cycle; one store bank takes the write and every bank
// two registered reads per cycle, the whole pipe stalls together on m_tready.
// Reset: position returns to column 0, row 0, coefficient to 7, pipe empties;
// the column store is not cleared.
// Top level of the horizontal diffusion stencil; uses hdiff_pkg, hdiff_store,
// hdiff_flux, hdiff_scale and the assertion macro header.
`include "horizontal_diffusion_stencil_top_macros.svh"

module horizontal_diffusion_stencil_top
    import hdiff_pkg::*;
#(
    parameter int WINDOW_COLUMNS = DEF_WINDOW_COLUMNS,
    parameter int WINDOW_ROWS    = DEF_WINDOW_ROWS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,   // [31:0] sample
    input  logic                 s_tuser,   // [0] window_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] result, [37:32] column_index,
                                            // [43:38] row_index, [47:44] zero
    output logic                 m_tlast,   // window_done
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [COEF_W-1:0]    cfg_data   // diffusion_coefficient
);

    localparam int ROW_LSB = SAMPLE_W + IDX_W;

    logic              advance, accept;
    logic [COEF_W-1:0] coef_reg;
    taps_t             taps;
    point_t            point1, point3, point_out;
    net_t              net;
    sample_t           center, result;

    // whole pipe moves when the result register is free or being taken
    assign advance  = !point_out.valid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    // coefficient register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= COEF_RESET;
        end else if (cfg_valid) begin
            coef_reg <= cfg_data;
        end
    end

    hdiff_store #(
        .WINDOW_COLUMNS (WINDOW_COLUMNS),
        .WINDOW_ROWS    (WINDOW_ROWS)
    ) u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .advance      (advance),
        .sample       (s_tdata),
        .window_start (s_tuser),
        .taps         (taps),
        .point        (point1)
    );

    hdiff_flux u_flux (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .taps      (taps),
        .point_in  (point1),
        .net       (net),
        .center    (center),
        .point_out (point3)
    );

    hdiff_scale u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .coef      (coef_reg),
        .net       (net),
        .center    (center),
        .point_in  (point3),
        .result    (result),
        .point_out (point_out)
    );

    // result item packing
    assign m_tvalid = point_out.valid;
    assign m_tdata  = {{M_PAD_W{1'b0}}, point_out.row_index, point_out.column_index, result};
    assign m_tlast  = point_out.window_done;

    `HDS_ASSERT(a_stall_blocks_input, aclk, aresetn, m_tvalid && !m_tready |-> !s_tready, "input taken while result stalled")
    `HDS_ASSERT(a_last_row, aclk, aresetn, m_tvalid && m_tlast |-> m_tdata[ROW_LSB +: IDX_W] == IDX_W'(WINDOW_ROWS - 3), "window end flagged off the last interior row")
    `HDS_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> coef_reg == COEF_RESET && !m_tvalid, "reset left coefficient or result valid")

endmodule

[tb/sv/horizontal_diffusion_stencil_top_test.sv]
// Self-checking testbench for horizontal_diffusion_stencil_top.
// Depends on hdiff_pkg and the block's RTL; a tracker class predicts every stencil
// point from the accepted samples, and plain tasks drive the input stream and the register.
module horizontal_diffusion_stencil_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hdiff_pkg::*;

    localparam int COLS          = DEF_WINDOW_COLUMNS;
    localparam int ROWS          = DEF_WINDOW_ROWS;
    localparam int ROW_AW        = $clog2(ROWS);
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    // sample shapes of one window
    typedef enum int {
        PAT_UNIFORM,
        PAT_SMALL,
        PAT_EXTREME,
        PAT_CHECKER,
        PAT_RAMP
    } pattern_t;

    // one diffused point as it leaves the block
    typedef struct packed {
        logic [SAMPLE_W-1:0] result;
        logic [IDX_W-1:0]    column_index;
        logic [IDX_W-1:0]    row_index;
        logic                window_done;
    } stencil_point_t;

    // Tracks window position, the last four columns and the coefficient,
    // and holds the diffused points still owed by the block.
    class stencil_tracker_t;
        bit [SAMPLE_W-1:0] column_mem [4][ROWS];
        int unsigned       col_pos;
        int unsigned       row_pos;
        int unsigned       coefficient;
        stencil_point_t    pending_points[$];
        int                mismatches;

        function new();
            col_pos     = 0;
            row_pos     = 0;
            coefficient = 32'(COEF_RESET);
            mismatches  = 0;
        endfunction

        function void set_coefficient(logic [COEF_W-1:0] value);
            coefficient = 32'(value);
        endfunction

        function longint tap(int unsigned col, int unsigned row);
            return longint'($signed(column_mem[2'(col)][ROW_AW'(row)]));
        endfunction

        static function longint laplace(longint mid, longint a, longint b,
                                        longint c, longint d);
            return 4 * mid - a - b - c - d;
        endfunction

        // flux dropped when it points the same way as the gradient
        static function longint limited_flux(longint flux, longint grad);
            if ((flux > 0 && grad > 0) || (flux < 0 && grad < 0))
                return 0;
            return flux;
        endfunction

        // accepted sample: predict the point it completes, then store it
        function void take_sample(logic [SAMPLE_W-1:0] value, logic start);
            int unsigned    p;
            int unsigned    q;
            longint         t[13];
            longint         lap_mid, lap_up, lap_down, lap_west, lap_east;
            longint         net, val;
            stencil_point_t pt;
            if (start) begin
                col_pos = 0;
                row_pos = 0;
            end
            p = col_pos;
            q = row_pos;
            if (p >= 4 && q >= 2 && q + 3 <= ROWS) begin
                t[0]  = tap(p - 2, q);
                t[1]  = tap(p - 2, q - 1);
                t[2]  = tap(p - 2, q + 1);
                t[3]  = tap(p - 2, q - 2);
                t[4]  = tap(p - 2, q + 2);
                t[5]  = tap(p - 3, q);
                t[6]  = tap(p - 3, q - 1);
                t[7]  = tap(p - 3, q + 1);
                t[8]  = tap(p - 1, q);
                t[9]  = tap(p - 1, q - 1);
                t[10] = tap(p - 1, q + 1);
                t[11] = tap(p - 4, q);
                t[12] = longint'($signed(value));

                lap_mid  = laplace(t[0], t[1], t[2], t[5], t[8]);
                lap_up   = laplace(t[1], t[3], t[0], t[6], t[9]);
                lap_down = laplace(t[2], t[0], t[4], t[7], t[10]);
                lap_west = laplace(t[5], t[6], t[7], t[11], t[0]);
                lap_east = laplace(t[8], t[9], t[10], t[0], t[12]);

                net = limited_flux(lap_down - lap_mid, t[2] - t[0])
                    - limited_flux(lap_mid - lap_up, t[0] - t[1])
                    + limited_flux(lap_east - lap_mid, t[8] - t[0])
                    - limited_flux(lap_mid - lap_west, t[0] - t[5]);
                val = t[0] - longint'(coefficient) * net;
                if (val > longint'(SAT_MAX))
                    val = longint'(SAT_MAX);
                if (val < longint'(SAT_MIN))
                    val = longint'(SAT_MIN);

                pt.result       = val[SAMPLE_W-1:0];
                pt.column_index = IDX_W'(p - 2);
                pt.row_index    = IDX_W'(q);
                pt.window_done  = (p + 1 == COLS) && (q + 3 == ROWS);
                pending_points.push_back(pt);
            end
            column_mem[2'(p)][ROW_AW'(q)] = value;
            row_pos = q + 1;
            if (row_pos >= ROWS) begin
                row_pos = 0;
                col_pos = p + 1;
                if (col_pos >= COLS)
                    col_pos = 0;
            end
        endfunction

        // result item from the block against the oldest owed point
        function void compare_point(logic [M_TDATA_W-1:0] data, logic last);
            stencil_point_t want;
            stencil_point_t got;
            got.result       = data[SAMPLE_W-1:0];
            got.column_index = data[SAMPLE_W +: IDX_W];
            got.row_index    = data[SAMPLE_W + IDX_W +: IDX_W];
            got.window_done  = last;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result item: %h col %0d row %0d last %b",
                             got.result, got.column_index, got.row_index, got.window_done);
                return;
            end
            want = pending_points.pop_front();
            if (got !== want || data[M_TDATA_W-1 -: M_PAD_W] !== '0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"point mismatch: expected %h col %0d row %0d last %b,",
                              " got %h col %0d row %0d last %b pad %h"},
                             want.result, want.column_index, want.row_index,
                             want.window_done, got.result, got.column_index,
                             got.row_index, got.window_done,
                             data[M_TDATA_W-1 -: M_PAD_W]);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [COEF_W-1:0]    cfg_data  = '0;

    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               cycle_count   = 0;
    stencil_tracker_t tracker       = new();

    horizontal_diffusion_stencil_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.compare_point(m_tdata, m_tlast);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("horizontal_diffusion_stencil_top_test failed");
            $finish;
        end
    end

    // one sample item, with random idle cycles ahead of it
    task automatic push_sample(logic [SAMPLE_W-1:0] value, logic start);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        tracker.take_sample(value, start);
    endtask

    task automatic write_coefficient(logic [COEF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_coefficient(value);
    endtask

    // drain owed points, then give the pipe time to empty of pointless items
    task automatic settle();
        int n;
        n = 0;
        while (tracker.pending_points.size() != 0)
            @(posedge aclk);
        while (n < SETTLE_CYCLES) begin
            @(posedge aclk);
            if (m_tready)
                n++;
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] pattern_sample(pattern_t pat, int unsigned k,
                                                            int base, int slope_c,
                                                            int slope_r);
        int col;
        int row;
        col = int'(k / ROWS);
        row = int'(k % ROWS);
        case (pat)
            PAT_UNIFORM: return $urandom();
            PAT_SMALL:   return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
            PAT_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return SAT_MAX;
                    1:       return SAT_MIN;
                    2:       return '0;
                    3:       return '1;
                    default: return SAMPLE_W'(1);
                endcase
            end
            PAT_CHECKER: begin
                if ($urandom_range(0, 7) == 0)
                    return $urandom();
                return ((col + row) & 1) ? SAT_MAX : SAT_MIN;
            end
            default: begin
                return SAMPLE_W'(base + slope_c * col + slope_r * row
                                 + int'($urandom_range(0, 16)) - 8);
            end
        endcase
    endfunction

    // a run of samples; stray window starts restart the position inside it
    task automatic run_window(int unsigned length, pattern_t pat, bit with_start,
                              int unsigned stray_per_mille);
        int unsigned n;
        int unsigned k;
        int          base;
        int          slope_c;
        int          slope_r;
        logic        start;
        base    = $urandom();
        slope_c = int'($urandom_range(0, 2000)) - 1000;
        slope_r = int'($urandom_range(0, 2000)) - 1000;
        k       = 0;
        for (n = 0; n < length; n++) begin
            start = (n == 0 && with_start) || ($urandom_range(0, 999) < stray_per_mille);
            if (start)
                k = 0;
            push_sample(pattern_sample(pat, k, base, slope_c, slope_r), start);
            k++;
        end
        s_tvalid <= 1'b0;
    endtask

    // windows of random shape, coefficient rewritten while idle between them
    task automatic run_phase(int send_pct, int recv_pct, int unsigned budget);
        int unsigned       sent;
        int unsigned       len;
        logic [COEF_W-1:0] coef;
        sent          = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent < budget) begin
            settle();
            case ($urandom_range(0, 4))
                0:       coef = '0;
                1:       coef = '1;
                2:       coef = COEF_W'(1);
                3:       coef = COEF_RESET;
                default: coef = COEF_W'($urandom_range(0, 255));
            endcase
            write_coefficient(coef);
            if ($urandom_range(0, 5) == 0)
                len = $urandom_range(1, 120);
            else
                len = $urandom_range(260, 520);
            if (len > budget - sent)
                len = budget - sent;
            run_window(len, pattern_t'($urandom_range(0, 4)), $urandom_range(0, 5) != 0,
                       ($urandom_range(0, 3) == 0) ? 3 : 0);
            sent += len;
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // field extremes and mid-window restarts under the reset coefficient;
        // all of these are border points
        send_idle_pct = 28;
        recv_idle_pct = 50;
        push_sample(SAT_MAX, 1'b1);
        push_sample(SAT_MIN, 1'b0);
        push_sample('0, 1'b0);
        push_sample('1, 1'b0);
        push_sample(SAMPLE_W'(1), 1'b0);
        push_sample(32'h0001_0000, 1'b0);
        push_sample(32'hffff_0000, 1'b1);
        push_sample(32'h5555_5555, 1'b0);
        push_sample(32'haaaa_aaaa, 1'b1);
        push_sample(SAT_MAX, 1'b0);
        push_sample(SAT_MIN, 1'b1);
        s_tvalid <= 1'b0;

        run_phase(28, 50, 580);
        run_phase(50, 28, 580);
        run_phase(0, 0, 580);

        settle();
        if (tracker.mismatches == 0)
            $display("horizontal_diffusion_stencil_top_test passed");
        else
            $display("horizontal_diffusion_stencil_top_test failed");
        $finish;
    end

endmodule
